>>> hdl/wmo_pkg.sv
// ----------------------------------------------------------------------------
// wmo_pkg
// shared types, constants and functions of the watermark overlay
// ----------------------------------------------------------------------------
`default_nettype none

package wmo_pkg;

  localparam int MaxWidth  = 4096;
  localparam int MaxHeight = 4096;

  localparam int Lanes     = 16;
  localparam int LaneW     = $clog2(Lanes);
  localparam int PixW      = 32;
  localparam int FieldW    = 64;
  localparam int ColW      = 13;
  localparam int RowW      = 4;
  localparam int CfgDataW  = 13;
  localparam int CfgIdxW   = 2;
  localparam int WordsW    = 21;
  localparam int ProdW     = 2 * CfgDataW;

  localparam logic [7:0] MarkAdd = 8'd15;
  localparam logic [7:0] ChanMax = 8'hff;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CfgImageWidth  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgImageHeight = CfgIdxW'(1);

  // position of lane 0 for the word in flight
  typedef struct packed {
    logic [ColW-1:0]     col;
    logic [RowW-1:0]     row;
    logic [CfgDataW-1:0] width;
    logic                last;
  } pos_t;

  function automatic logic [CfgDataW-1:0] clamp_width(input logic [CfgDataW-1:0] v);
    logic [CfgDataW-1:0] r;
    r = v;
    if (int'(v) < Lanes) r = CfgDataW'(Lanes);
    else if (int'(v) > MaxWidth) r = CfgDataW'(MaxWidth);
    return r;
  endfunction

  function automatic logic [CfgDataW-1:0] clamp_height(input logic [CfgDataW-1:0] v);
    logic [CfgDataW-1:0] r;
    r = v;
    if (v == '0) r = CfgDataW'(1);
    else if (int'(v) > MaxHeight) r = CfgDataW'(MaxHeight);
    return r;
  endfunction

  // x-shaped mark on a 16x16 tile, border rows and columns blank
  function automatic logic [7:0] mark_at(input logic [3:0] c, input logic [3:0] r);
    logic [7:0] m;
    m = '0;
    if (c != 4'd0 && c != 4'd15 && r != 4'd0 && r != 4'd15) begin
      if (c == r || (c + r) == 4'd15) m = MarkAdd;
    end
    return m;
  endfunction

  // ceil(width * height / 16)
  function automatic logic [WordsW-1:0] word_total(input logic [CfgDataW-1:0] w,
                                                   input logic [CfgDataW-1:0] h);
    logic [ProdW-1:0] p;
    p = ProdW'(w) * ProdW'(h);
    p = p + ProdW'(Lanes - 1);
    return WordsW'(p >> LaneW);
  endfunction

endpackage

`default_nettype wire

>>> hdl/wmo_if.sv
// ----------------------------------------------------------------------------
// wmo_if
// stream and configuration interfaces of the watermark overlay
// ----------------------------------------------------------------------------
`default_nettype none

interface wmo_pix_if;
  logic        valid;
  logic        ready;
  logic [63:0] pixels_00_01;
  logic [63:0] pixels_02_03;
  logic [63:0] pixels_04_05;
  logic [63:0] pixels_06_07;
  logic [63:0] pixels_08_09;
  logic [63:0] pixels_10_11;
  logic [63:0] pixels_12_13;
  logic [63:0] pixels_14_15;

  modport source (
    output valid, pixels_00_01, pixels_02_03, pixels_04_05, pixels_06_07,
           pixels_08_09, pixels_10_11, pixels_12_13, pixels_14_15,
    input  ready
  );
  modport sink (
    input  valid, pixels_00_01, pixels_02_03, pixels_04_05, pixels_06_07,
           pixels_08_09, pixels_10_11, pixels_12_13, pixels_14_15,
    output ready
  );
endinterface

interface wmo_mark_if;
  logic        valid;
  logic        ready;
  logic [63:0] marked_00_01;
  logic [63:0] marked_02_03;
  logic [63:0] marked_04_05;
  logic [63:0] marked_06_07;
  logic [63:0] marked_08_09;
  logic [63:0] marked_10_11;
  logic [63:0] marked_12_13;
  logic [63:0] marked_14_15;
  logic        last_word;

  modport source (
    output valid, marked_00_01, marked_02_03, marked_04_05, marked_06_07,
           marked_08_09, marked_10_11, marked_12_13, marked_14_15, last_word,
    input  ready
  );
  modport sink (
    input  valid, marked_00_01, marked_02_03, marked_04_05, marked_06_07,
           marked_08_09, marked_10_11, marked_12_13, marked_14_15, last_word,
    output ready
  );
endinterface

interface wmo_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [12:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hdl/image_watermark_saturating_overlay.sv
// ----------------------------------------------------------------------------
// image_watermark_saturating_overlay
// adds a 16x16 x-shaped mark to a stream of 16-pixel image words
// ----------------------------------------------------------------------------
// usage:
//   pix_i carries one word of sixteen packed rgb pixels per handshake; mark_o
//   returns the marked word with the top byte of every pixel cleared and
//   last_word set on word ceil(width*height/16) of the frame, after which the
//   position returns to the frame start. cfg_i writes image_width (index 0)
//   and image_height (index 1); out-of-range values are clamped on write; the
//   user must see that they are written only while no word is in flight, as
//   the block itself does not enforce it. throughput: one word per cycle
//   while mark_o.ready is high, set by the sixteen lanes that each mark one
//   pixel in parallel; a word passes the lane stage, then the output register.
//   pipeline: frame position (lane 0 column, row mod 16) is resolved at the
//   input edge, the lanes mark in the lane stage, the output register
//   merges the lanes into the result word.
//   reset: rst_ni clears both stages and the frame position and restores a
//   16x1 image; no sweep is needed.
//   stall: when mark_o.ready is low the output word holds; one more word can
//   still be taken into the lane stage, then pix_i.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module image_watermark_saturating_overlay (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  wmo_cfg_if.sink   cfg_i,
  wmo_pix_if.sink   pix_i,
  wmo_mark_if.source mark_o
);
  import wmo_pkg::*;

  // unpacked pixels of the incoming word
  logic [PixW-1:0] pix_in [Lanes];

  // lane stage
  logic            a_valid_q, a_valid_d;
  pos_t            a_pos_q;
  logic [PixW-1:0] a_pix_q [Lanes];

  // output register
  logic            b_valid_q, b_valid_d;
  logic            b_last_q;
  logic [PixW-1:0] b_pix_q [Lanes];

  logic [PixW-1:0] lane_out [Lanes];
  pos_t            pos;
  logic            in_acc;
  logic            a_adv;

  assign pix_in[0]  = pix_i.pixels_00_01[31:0];
  assign pix_in[1]  = pix_i.pixels_00_01[63:32];
  assign pix_in[2]  = pix_i.pixels_02_03[31:0];
  assign pix_in[3]  = pix_i.pixels_02_03[63:32];
  assign pix_in[4]  = pix_i.pixels_04_05[31:0];
  assign pix_in[5]  = pix_i.pixels_04_05[63:32];
  assign pix_in[6]  = pix_i.pixels_06_07[31:0];
  assign pix_in[7]  = pix_i.pixels_06_07[63:32];
  assign pix_in[8]  = pix_i.pixels_08_09[31:0];
  assign pix_in[9]  = pix_i.pixels_08_09[63:32];
  assign pix_in[10] = pix_i.pixels_10_11[31:0];
  assign pix_in[11] = pix_i.pixels_10_11[63:32];
  assign pix_in[12] = pix_i.pixels_12_13[31:0];
  assign pix_in[13] = pix_i.pixels_12_13[63:32];
  assign pix_in[14] = pix_i.pixels_14_15[31:0];
  assign pix_in[15] = pix_i.pixels_14_15[63:32];

  // handshake: lane stage moves on whenever the output register is free
  assign a_adv       = !b_valid_q || mark_o.ready;
  assign pix_i.ready = !a_valid_q || a_adv;
  assign in_acc      = pix_i.valid && pix_i.ready;

  // frame position tracker, advanced once per accepted word
  wmo_frame u_frame (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .adv_i  (in_acc),
    .pos_o  (pos)
  );

  // sixteen marking lanes on the lane stage
  for (genvar g = 0; g < Lanes; g++) begin : g_lane
    wmo_lane u_lane (
      .lane_i (LaneW'(g)),
      .pos_i  (a_pos_q),
      .pix_i  (a_pix_q[g]),
      .pix_o  (lane_out[g])
    );
  end

  always_comb begin
    a_valid_d = a_valid_q;
    if (in_acc) a_valid_d = 1'b1;
    else if (a_adv) a_valid_d = 1'b0;
    b_valid_d = a_adv ? a_valid_q : b_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      b_valid_q <= b_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_pos_q <= pos;
      a_pix_q <= pix_in;
    end
    if (a_adv && a_valid_q) begin
      b_pix_q  <= lane_out;
      b_last_q <= a_pos_q.last;
    end
  end

  // merge the lanes back into the output word
  assign mark_o.valid        = b_valid_q;
  assign mark_o.last_word    = b_last_q;
  assign mark_o.marked_00_01 = {b_pix_q[1],  b_pix_q[0]};
  assign mark_o.marked_02_03 = {b_pix_q[3],  b_pix_q[2]};
  assign mark_o.marked_04_05 = {b_pix_q[5],  b_pix_q[4]};
  assign mark_o.marked_06_07 = {b_pix_q[7],  b_pix_q[6]};
  assign mark_o.marked_08_09 = {b_pix_q[9],  b_pix_q[8]};
  assign mark_o.marked_10_11 = {b_pix_q[11], b_pix_q[10]};
  assign mark_o.marked_12_13 = {b_pix_q[13], b_pix_q[12]};
  assign mark_o.marked_14_15 = {b_pix_q[15], b_pix_q[14]};

endmodule

`default_nettype wire

>>> hdl/wmo_lane.sv
// ----------------------------------------------------------------------------
// wmo_lane
// one pixel lane: mark lookup and saturating add on red, green and blue
// ----------------------------------------------------------------------------
`default_nettype none

module wmo_lane (
  input  wire logic [wmo_pkg::LaneW-1:0]    lane_i,
  input  wire wmo_pkg::pos_t                pos_i,
  input  wire logic [wmo_pkg::PixW-1:0]     pix_i,
  output logic      [wmo_pkg::PixW-1:0]     pix_o
);
  import wmo_pkg::*;

  logic [ColW-1:0] cx;
  logic [ColW-1:0] cx_wrap;
  logic            wrap;
  logic [3:0]      c;
  logic [3:0]      r;
  logic [7:0]      m;
  logic [8:0]      s;

  always_comb begin
    cx      = pos_i.col + ColW'(lane_i);
    wrap    = cx >= pos_i.width;
    cx_wrap = cx - pos_i.width;
    c       = wrap ? cx_wrap[3:0] : cx[3:0];
    r       = wrap ? pos_i.row + 4'd1 : pos_i.row;
    m       = mark_at(c, r);
    pix_o   = '0;
    s       = '0;
    for (int k = 0; k < 3; k++) begin
      s = {1'b0, pix_i[8*k +: 8]} + {1'b0, m};
      pix_o[8*k +: 8] = s[8] ? ChanMax : s[7:0];
    end
  end

endmodule

`default_nettype wire

>>> hdl/wmo_frame.sv
// ----------------------------------------------------------------------------
// wmo_frame
// configuration registers, word count and position of lane 0 in the frame
// ----------------------------------------------------------------------------
`default_nettype none

module wmo_frame (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  wmo_cfg_if.sink     cfg_i,
  input  wire logic   adv_i,
  output wmo_pkg::pos_t pos_o
);
  import wmo_pkg::*;

  logic [CfgDataW-1:0] width_q, width_d;
  logic [CfgDataW-1:0] height_q, height_d;
  logic [WordsW-1:0]   total_q, total_d;
  logic [ColW-1:0]     col_q, col_d;
  logic [RowW-1:0]     row_q, row_d;
  logic [WordsW-1:0]   words_q, words_d;

  logic [ColW-1:0]     col_a;
  logic [ColW-1:0]     col_b;
  logic [RowW-1:0]     row_a;
  logic                last;
  logic                cfg_wr;
  logic [CfgDataW-1:0] wc;
  logic [CfgDataW-1:0] hc;

  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.valid & cfg_i.ready;

  // config path; the word total is rebuilt on each width or height write
  always_comb begin
    wc       = clamp_width(cfg_i.data);
    hc       = clamp_height(cfg_i.data);
    width_d  = width_q;
    height_d = height_q;
    total_d  = total_q;
    if (cfg_wr) begin
      if (cfg_i.index == CfgImageWidth) begin
        width_d = wc;
        total_d = word_total(wc, height_q);
      end else if (cfg_i.index == CfgImageHeight) begin
        height_d = hc;
        total_d  = word_total(width_q, hc);
      end
    end
  end

  // row wrap of lane 0, at most once per word
  always_comb begin
    col_a = col_q;
    row_a = row_q;
    if (col_q >= width_q) begin
      col_a = col_q - width_q;
      row_a = row_q + RowW'(1);
    end
    col_b = (col_a >= width_q) ? '0 : col_a;
    last  = ({1'b0, words_q} + (WordsW + 1)'(1)) >= {1'b0, total_q};
  end

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    words_d = words_q;
    if (adv_i) begin
      if (last) begin
        col_d   = '0;
        row_d   = '0;
        words_d = '0;
      end else begin
        col_d   = col_b + ColW'(Lanes);
        row_d   = row_a;
        words_d = words_q + WordsW'(1);
      end
    end
  end

  assign pos_o = '{col: col_b, row: row_a, width: width_q, last: last};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CfgDataW'(Lanes);
      height_q <= CfgDataW'(1);
      total_q  <= WordsW'(1);
      col_q    <= '0;
      row_q    <= '0;
      words_q  <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      total_q  <= total_d;
      col_q    <= col_d;
      row_q    <= row_d;
      words_q  <= words_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/wmo_checker.sv
// ----------------------------------------------------------------------------
// wmo_checker
// port-level checks of the watermark overlay, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module wmo_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [63:0] out_word_i,
  input wire logic        out_last_i
);

  logic [1:0] cnt_q, cnt_d;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (in_acc && !out_acc) cnt_d = cnt_q + 2'd1;
    else if (!in_acc && out_acc) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else cnt_q <= cnt_d;
  end

  // stalled word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_word_i)
                                   && $stable(out_last_i))
    else $error("stalled output word changed");

  // two pipeline stages: never more than two words in flight, none invented
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != 2'd3) && (!out_valid_i || cnt_q != 2'd0))
    else $error("words in flight out of range");

  // a word taken into an empty pipeline shows once through both stages
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && cnt_q == 2'd0 |-> ##2 out_valid_i)
    else $error("output word late");

  // alpha byte of pixels 0 and 1, the field bound here, is cleared
  a_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_word_i[63:56] == 8'd0 && out_word_i[31:24] == 8'd0)
    else $error("top pixel byte not cleared");

endmodule

bind image_watermark_saturating_overlay wmo_checker u_wmo_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pix_i.valid),
  .in_ready_i  (pix_i.ready),
  .out_valid_i (mark_o.valid),
  .out_ready_i (mark_o.ready),
  .out_word_i  (mark_o.marked_00_01),
  .out_last_i  (mark_o.last_word)
);

`default_nettype wire

>>> sim/image_watermark_saturating_overlay_tb.sv
// ----------------------------------------------------------------------------
// image_watermark_saturating_overlay_tb
// self-checking bench for the saturating watermark overlay: words of sixteen
// pixels go in under random source and sink stalls, a model of the 16x16
// x-shaped mark predicts every output word and its last flag, and the image
// size is changed between phases, including mid-frame and out-of-range sizes
// ----------------------------------------------------------------------------
`default_nettype none

module image_watermark_saturating_overlay_tb;
  import wmo_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit   = 400000;
  localparam int RandomWords  = 1750;
  localparam int LongHold     = 64;   // receiver hold-off, in cycles
  localparam int DrainPause   = 4;    // covers the lane stage and output register, plus margin
  localparam int FieldCount   = Lanes / 2;

  // index values the block has no register behind
  localparam logic [CfgIdxW-1:0] CfgSpareA = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgSpareB = CfgIdxW'(3);

  typedef logic [FieldCount-1:0][FieldW-1:0] pix_word_t;

  typedef struct {
    pix_word_t marked;
    logic      last;
  } marked_word_t;

  // predicts the marked words and keeps them in order until they come out
  class overlay_scoreboard;
    logic [CfgDataW-1:0] width_reg;
    logic [CfgDataW-1:0] height_reg;
    int unsigned         lane0_col;
    int unsigned         row_mod16;
    int unsigned         words_in_frame;
    marked_word_t        marked_q[$];
    int unsigned         errors;
    int unsigned         words_checked;
    int unsigned         frames_seen;
    int unsigned         reg_writes;

    function new();
      width_reg      = CfgDataW'(Lanes);
      height_reg     = CfgDataW'(1);
      lane0_col      = 0;
      row_mod16      = 0;
      words_in_frame = 0;
      errors         = 0;
      words_checked  = 0;
      frames_seen    = 0;
      reg_writes     = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      reg_writes++;
      if (idx == CfgImageWidth) width_reg = val;
      else if (idx == CfgImageHeight) height_reg = val;
    endfunction

    function int unsigned used_width();
      int unsigned v;
      v = width_reg;
      if (v < Lanes) v = Lanes;
      if (v > MaxWidth) v = MaxWidth;
      return v;
    endfunction

    function int unsigned used_height();
      int unsigned v;
      v = height_reg;
      if (v < 1) v = 1;
      if (v > MaxHeight) v = MaxHeight;
      return v;
    endfunction

    function int unsigned frame_words();
      return (used_width() * used_height() + Lanes - 1) / Lanes;
    endfunction

    // x across the tile, nothing on the border rows and columns
    function int unsigned x_gain(int unsigned c, int unsigned r);
      c = c % 16;
      r = r % 16;
      if (c == 0 || c == 15 || r == 0 || r == 15) return 0;
      return (c == r || c + r == 15) ? MarkAdd : 0;
    endfunction

    function void note_word(pix_word_t w);
      int unsigned  wd;
      int unsigned  x;
      int unsigned  y;
      int unsigned  cx;
      int unsigned  cy;
      int unsigned  gain;
      int unsigned  s;
      logic [31:0]  px;
      logic [31:0]  res;
      marked_word_t exp_word;

      wd = used_width();
      x  = lane0_col;
      y  = row_mod16;
      // lane 0 may start past the row end after the previous word
      if (x >= wd) begin
        x = x - wd;
        y = (y + 1) % 16;
      end
      if (x >= wd) x = 0;

      exp_word.marked = '0;
      for (int i = 0; i < Lanes; i++) begin
        cx = x + i;
        cy = y;
        if (cx >= wd) begin
          cx = cx - wd;
          cy = (cy + 1) % 16;
        end
        gain = x_gain(cx, cy);
        px   = w[i / 2][32 * (i % 2) +: 32];
        res  = '0;
        for (int k = 0; k < 3; k++) begin
          s = px[8 * k +: 8] + gain;
          if (s > ChanMax) s = ChanMax;
          res[8 * k +: 8] = s[7:0];
        end
        exp_word.marked[i / 2][32 * (i % 2) +: 32] = res;
      end

      exp_word.last = (words_in_frame + 1 >= frame_words());
      if (exp_word.last) begin
        lane0_col      = 0;
        row_mod16      = 0;
        words_in_frame = 0;
      end else begin
        lane0_col      = (x + Lanes) % (1 << ColW);
        row_mod16      = y % 16;
        words_in_frame = (words_in_frame + 1) % (1 << WordsW);
      end
      marked_q.push_back(exp_word);
    endfunction

    function void check_word(marked_word_t got);
      marked_word_t exp_word;
      if (marked_q.size() == 0) begin
        $display("%0t: marked word with nothing expected, last_word %b", $time, got.last);
        errors++;
        return;
      end
      exp_word = marked_q.pop_front();
      words_checked++;
      if (got.last === 1'b1) frames_seen++;
      for (int f = 0; f < FieldCount; f++) begin
        if (got.marked[f] !== exp_word.marked[f]) begin
          $display("%0t: marked_%02d_%02d mismatch expected %h actual %h",
                   $time, 2 * f, 2 * f + 1, exp_word.marked[f], got.marked[f]);
          errors++;
        end
      end
      if (got.last !== exp_word.last) begin
        $display("%0t: last_word mismatch expected %b actual %b",
                 $time, exp_word.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic recv_ready = 1'b0;
  logic hold_toggle = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int unsigned cycle_count = 0;

  overlay_scoreboard sb = new();

  wmo_cfg_if  cfg_bus ();
  wmo_pix_if  pix_bus ();
  wmo_mark_if mark_bus ();

  assign mark_bus.ready = recv_ready;

  image_watermark_saturating_overlay dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_bus),
    .pix_i  (pix_bus),
    .mark_o (mark_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run guard: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: no progress after %0d cycles", $time, cycle_count);
      $display("image_watermark_saturating_overlay regression: fail");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off whenever the stimulus
  // flips hold_toggle
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      recv_ready <= 1'b0;
      hold_seen  <= 1'b0;
      hold_left  <= 0;
    end else if (hold_toggle != hold_seen) begin
      hold_seen  <= hold_toggle;
      hold_left  <= LongHold - 1;
      recv_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      recv_ready <= 1'b0;
    end else begin
      recv_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: all three channels sampled at the edge, before any update
  always @(posedge clk) begin
    pix_word_t    in_word;
    marked_word_t out_word;
    if (rst_n) begin
      if (cfg_bus.valid && cfg_bus.ready) sb.write_reg(cfg_bus.index, cfg_bus.data);
      if (pix_bus.valid && pix_bus.ready) begin
        in_word[0] = pix_bus.pixels_00_01;
        in_word[1] = pix_bus.pixels_02_03;
        in_word[2] = pix_bus.pixels_04_05;
        in_word[3] = pix_bus.pixels_06_07;
        in_word[4] = pix_bus.pixels_08_09;
        in_word[5] = pix_bus.pixels_10_11;
        in_word[6] = pix_bus.pixels_12_13;
        in_word[7] = pix_bus.pixels_14_15;
        sb.note_word(in_word);
      end
      if (mark_bus.valid && mark_bus.ready) begin
        out_word.marked[0] = mark_bus.marked_00_01;
        out_word.marked[1] = mark_bus.marked_02_03;
        out_word.marked[2] = mark_bus.marked_04_05;
        out_word.marked[3] = mark_bus.marked_06_07;
        out_word.marked[4] = mark_bus.marked_08_09;
        out_word.marked[5] = mark_bus.marked_10_11;
        out_word.marked[6] = mark_bus.marked_12_13;
        out_word.marked[7] = mark_bus.marked_14_15;
        out_word.last      = mark_bus.last_word;
        sb.check_word(out_word);
      end
    end
  end

  // sixteen copies of one pixel
  function automatic pix_word_t fill_word(logic [31:0] px);
    return {Lanes{px}};
  endfunction

  // random word; a third of its fields pushed toward the saturation range
  function automatic pix_word_t rand_word();
    pix_word_t w;
    for (int f = 0; f < FieldCount; f++) begin
      w[f] = {$urandom, $urandom};
      if ($urandom_range(2) == 0) w[f] = w[f] | 64'hf0f0f0f0_f0f0f0f0;
    end
    return w;
  endfunction

  // offer one word and hold it until the block takes it
  task automatic offer_word(input pix_word_t w);
    pix_bus.valid        <= 1'b1;
    pix_bus.pixels_00_01 <= w[0];
    pix_bus.pixels_02_03 <= w[1];
    pix_bus.pixels_04_05 <= w[2];
    pix_bus.pixels_06_07 <= w[3];
    pix_bus.pixels_08_09 <= w[4];
    pix_bus.pixels_10_11 <= w[5];
    pix_bus.pixels_12_13 <= w[6];
    pix_bus.pixels_14_15 <= w[7];
    @(posedge clk);
    while (!pix_bus.ready) @(posedge clk);
  endtask

  // idle cycles between words, one valid update per edge
  task automatic sender_gap();
    while ($urandom_range(99) < send_idle_pct) begin
      pix_bus.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // stop offering and wait until every marked word has come back; an edge
  // first so the monitor has queued the word taken at the last edge
  task automatic drain_results();
    pix_bus.valid <= 1'b0;
    @(posedge clk);
    while (sb.marked_q.size() != 0) @(posedge clk);
    repeat (DrainPause) @(posedge clk);
  endtask

  // write one or both size registers back to back, valid lowered once at the end
  task automatic set_image_size(input logic [CfgDataW-1:0] wd, input logic [CfgDataW-1:0] ht,
                                input bit do_width, input bit do_height);
    if (do_width) begin
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= CfgImageWidth;
      cfg_bus.data  <= wd;
      @(posedge clk);
      while (!cfg_bus.ready) @(posedge clk);
    end
    if (do_height) begin
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= CfgImageHeight;
      cfg_bus.data  <= ht;
      @(posedge clk);
      while (!cfg_bus.ready) @(posedge clk);
    end
    cfg_bus.valid <= 1'b0;
  endtask

  initial begin
    logic [CfgDataW-1:0] wd;
    logic [CfgDataW-1:0] ht;
    int unsigned random_count;
    int unsigned phase_words;
    int unsigned phase_idx;
    int unsigned frame_len;
    bit          do_width;
    bit          do_height;

    // every input known from time zero
    pix_bus.valid        <= 1'b0;
    pix_bus.pixels_00_01 <= '0;
    pix_bus.pixels_02_03 <= '0;
    pix_bus.pixels_04_05 <= '0;
    pix_bus.pixels_06_07 <= '0;
    pix_bus.pixels_08_09 <= '0;
    pix_bus.pixels_10_11 <= '0;
    pix_bus.pixels_12_13 <= '0;
    pix_bus.pixels_14_15 <= '0;
    cfg_bus.valid        <= 1'b0;
    cfg_bus.index        <= CfgImageWidth;
    cfg_bus.data         <= '0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---------------- directed words, no idling ----------------
    // reset size is 16x1: every word is a whole frame on row 0, so nothing
    // is marked and only the top byte clearing shows
    offer_word(fill_word(32'h0000_0000));
    offer_word(fill_word(32'hffff_ffff));
    // nothing is marked here, so this near-saturation pixel passes unchanged but for its top byte
    offer_word(fill_word(32'hfff1_f0ef));
    drain_results();

    // width below 16 is used as 16, sixteen rows: one full tile, one row
    // per word, covering both diagonals and the blank border
    set_image_size(CfgDataW'(0), CfgDataW'(16), 1'b1, 1'b1);
    for (int r = 0; r < 16; r++) begin
      case (r % 4)
        0: offer_word(fill_word(32'hfff1_f0ef));
        1: offer_word(fill_word(32'h0000_0000));
        2: offer_word(fill_word(32'hffff_ffff));
        default: offer_word(rand_word());
      endcase
    end
    drain_results();

    // width 24: lanes run past the row end and wrap to the next row
    // within a word; writes to the spare indexes must change nothing
    set_image_size(CfgDataW'(24), CfgDataW'(2), 1'b1, 1'b1);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= CfgSpareA;
    cfg_bus.data  <= '1;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.index <= CfgSpareB;
    cfg_bus.data  <= CfgDataW'(0);
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    for (int n = 0; n < 3; n++) offer_word(fill_word(32'hfff1_f0ef));
    drain_results();

    // oversized width, zero height: used as 4096 by 1, frame left unfinished
    set_image_size('1, CfgDataW'(0), 1'b1, 1'b1);
    for (int n = 0; n < 3; n++) offer_word(rand_word());
    drain_results();

    // ---------------- random phases ----------------
    // each phase picks a size, possibly mid-frame, and sends either whole
    // frames or a partial run; idling changes by thirds of the run
    random_count = 0;
    phase_idx    = 0;
    while (random_count < RandomWords) begin
      do_width  = ($urandom_range(4) != 0);
      do_height = ($urandom_range(4) != 0) || !do_width;
      if ($urandom_range(7) == 0) begin
        // extremes and clamped values, short partial runs only
        case ($urandom_range(5))
          0: wd = CfgDataW'(0);
          1: wd = CfgDataW'(15);
          2: wd = CfgDataW'(16);
          3: wd = CfgDataW'(MaxWidth);
          4: wd = CfgDataW'(MaxWidth + 1);
          default: wd = '1;
        endcase
        case ($urandom_range(4))
          0: ht = CfgDataW'(0);
          1: ht = CfgDataW'(1);
          2: ht = CfgDataW'(MaxHeight);
          3: ht = CfgDataW'(MaxHeight + 1);
          default: ht = '1;
        endcase
        set_image_size(wd, ht, do_width, do_height);
        phase_words = $urandom_range(40, 1);
      end else begin
        wd = CfgDataW'($urandom_range(80, 16));
        ht = CfgDataW'($urandom_range(24, 1));
        set_image_size(wd, ht, do_width, do_height);
        frame_len = sb.frame_words();
        if ($urandom_range(2) != 0) begin
          // whole frames, counted from wherever the old frame stopped
          phase_words = frame_len * $urandom_range(2, 1);
        end else begin
          // partial run: the next size change can fall mid-frame
          phase_words = $urandom_range(frame_len + 5, 1);
        end
      end

      // now and then the receiver holds off while words keep coming, so
      // the block fills up and pushes back on the input
      if (phase_idx % 7 == 5) begin
        if (phase_words < 20) phase_words = 20;
        hold_toggle <= ~hold_toggle;
      end

      for (int n = 0; n < phase_words; n++) begin
        if (random_count < RandomWords / 3) begin
          send_idle_pct = 10;
          recv_idle_pct = 79;
        end else if (random_count < 2 * RandomWords / 3) begin
          send_idle_pct = 79;
          recv_idle_pct = 10;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        offer_word(rand_word());
        random_count++;
        sender_gap();
      end
      // sender pauses here until the whole phase has come back
      drain_results();
      phase_idx++;
    end

    // nothing left in flight; a further wait catches stray words
    drain_results();
    repeat (2 * DrainPause) @(posedge clk);

    $display("checked %0d marked words in %0d completed frames over %0d phases",
             sb.words_checked, sb.frames_seen, phase_idx);
    $display("%0d register writes, out-of-range and mid-frame size changes included",
             sb.reg_writes);
    if (sb.errors == 0 && sb.marked_q.size() == 0) begin
      $display("image_watermark_saturating_overlay regression: pass");
    end else begin
      $display("image_watermark_saturating_overlay regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
